>>> hdl/pi_controller_antiwindup_assert.svh
// ----------------------------------------------------------------------------
// pi controller assertion macros
// shared concurrent check forms for the pi controller rtl
// ----------------------------------------------------------------------------
`ifndef PI_CONTROLLER_ANTIWINDUP_ASSERT_SVH
`define PI_CONTROLLER_ANTIWINDUP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PICA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pica: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define PICA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pica: next-cycle check failed");

`endif

>>> hdl/pica_pkg.sv
// ----------------------------------------------------------------------------
// pi controller package
// shared constants, register and mode codes, multiplier request type
// ----------------------------------------------------------------------------
package pica_pkg;

    localparam int SIGNAL_WIDTH_DEF = 16;
    localparam int GAIN_W           = 16;   // unsigned q8.8 gains and step time
    localparam int GAIN_FRAC        = 8;
    localparam int MODE_W           = 2;
    localparam int INTEG_W          = 24;   // q12.12 integral
    localparam int ONE_FIXED        = 4096; // 1.0 in q4.12
    localparam int CFG_IDX_W        = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_OFFSET = 3'd4;

    // register reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd256;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
    localparam logic [GAIN_W-1:0] STEP_TIME_RST  = 16'd256;

    // action modes, code three behaves as override
    localparam logic [MODE_W-1:0] MODE_OVERRIDE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FORWARD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REVERSE  = 2'd2;

    // request to the shared multiplier
    typedef struct packed {
        logic              en;
        logic [GAIN_W-1:0] gain;
    } t_mul_req;

endpackage

>>> hdl/pica_mul.sv
// ----------------------------------------------------------------------------
// pica shared multiplier
// unsigned gain times signed operand, registered, then rounded by 2^-8
// ----------------------------------------------------------------------------
module pica_mul #(
    parameter  int BW = 25,
    localparam int PW = pica_pkg::GAIN_W + 1 + BW,
    localparam int RW = PW - pica_pkg::GAIN_FRAC
) (
    input  logic                      i_clk,
    input  pica_pkg::t_mul_req        i_req,
    input  logic signed [BW-1:0]      i_opb,
    output logic signed [RW-1:0]      o_rnd
);
    import pica_pkg::*;

    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] w_biased;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= $signed({1'b0, i_req.gain}) * i_opb;
        end
    end

    // add half an lsb, then floor: round to nearest, ties up
    assign w_biased = r_prod
                    + {{(PW - GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC - 1){1'b0}}};
    assign o_rnd    = RW'(w_biased >>> GAIN_FRAC);

endmodule

>>> hdl/pi_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pi controller with back-calculation anti-windup
// sequenced fixed-point pi loop around one shared gain multiplier
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                    contents (lowest bits first)
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: setpoint, measured
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: drive, integral_out;
//                                             tuser: clamped
// cfg       in   i_cfg_we                     i_cfg_idx selects, i_cfg_data
//
// closed loop: after the accept the sequencer steps through S_MP, S_MI, S_MT0,
//   S_MT, S_INC, S_INT, S_SUM and S_LIM; the one multiplier is used three
//   times (proportional, integral gain, step time), each product registered
//   and rounded before the next use; override (act_mode 0 or 3): from the
//   accept straight to S_LIM, which registers the result
// reset: synchronous active low, clears the integral and loads register defaults
// a result stalled on m_axis holds the sequencer in its final step; a new
//   transaction is taken as soon as the sequencer is back to idle
//
module pi_controller_antiwindup #(
    parameter  int SIGNAL_WIDTH = pica_pkg::SIGNAL_WIDTH_DEF,
    localparam int IN_TW  = ((2 * SIGNAL_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW = ((SIGNAL_WIDTH + pica_pkg::INTEG_W + 7) / 8) * 8,
    localparam int CFG_W  = (SIGNAL_WIDTH > pica_pkg::GAIN_W)
                          ? SIGNAL_WIDTH : pica_pkg::GAIN_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input transactions
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_TW-1:0]                  s_axis_tdata,  // setpoint, measured
    // result transactions
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [OUT_TW-1:0]                 m_axis_tdata,  // drive, integral_out
    output logic [0:0]                        m_axis_tuser,  // clamped
    // register writes
    input  logic                              i_cfg_we,
    input  logic [pica_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]                  i_cfg_data
);
    import pica_pkg::*;

    `include "pi_controller_antiwindup_assert.svh"

    // datapath widths
    localparam int W   = SIGNAL_WIDTH;
    localparam int EW  = W + 1;              // error
    localparam int BW  = W + 9;              // multiplier signed operand
    localparam int RW  = GAIN_W + 1 + BW - GAIN_FRAC; // rounded product
    localparam int XW  = RW + 1;             // integral plus increment
    localparam int SW  = RW + 2;             // proportional + integral + bias
    localparam int BCW = SW + 2;             // back-calculated integral

    localparam logic signed [XW-1:0]  X_MAX    = XW'(2 ** (INTEG_W - 1) - 1);
    localparam logic signed [XW-1:0]  X_MIN    = XW'(-(2 ** (INTEG_W - 1)));
    localparam logic signed [BCW-1:0] B_MAX    = BCW'(2 ** (INTEG_W - 1) - 1);
    localparam logic signed [BCW-1:0] B_MIN    = BCW'(-(2 ** (INTEG_W - 1)));
    localparam logic signed [SW-1:0]  LIM_POS  = SW'(ONE_FIXED);
    localparam logic signed [SW-1:0]  LIM_NEG  = SW'(-ONE_FIXED);
    localparam logic [W-1:0]          DRV_POS  = W'(ONE_FIXED);
    localparam logic [W-1:0]          DRV_NEG  = W'(-ONE_FIXED);

    // sequencer steps
    localparam logic [3:0] S_IDLE = 4'd0;  // wait for a transaction
    localparam logic [3:0] S_MP   = 4'd1;  // prop_gain * error
    localparam logic [3:0] S_MI   = 4'd2;  // integ_gain * error, take proportional
    localparam logic [3:0] S_MT0  = 4'd3;  // take rounded integral gain product
    localparam logic [3:0] S_MT   = 4'd4;  // times step_time
    localparam logic [3:0] S_INC  = 4'd5;  // take rounded increment
    localparam logic [3:0] S_INT  = 4'd6;  // integral + increment, saturate
    localparam logic [3:0] S_SUM  = 4'd7;  // proportional + integral + bias
    localparam logic [3:0] S_LIM  = 4'd8;  // limit, back-calculate, emit

    // configuration registers
    logic [GAIN_W-1:0]    r_prop_gain;
    logic [GAIN_W-1:0]    r_integ_gain;
    logic [GAIN_W-1:0]    r_step_time;
    logic [MODE_W-1:0]    r_act_mode;
    logic signed [W-1:0]  r_bias;

    // sequencer and state
    logic [3:0]              r_state, n_state;
    logic signed [INTEG_W-1:0] r_acc;
    logic                    r_ovr;

    // working registers
    logic signed [EW-1:0]      r_err;
    logic signed [RW-1:0]      r_prop;
    logic signed [RW-1:0]      r_inc;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [SW-1:0]      r_sum;

    // result register
    logic                      r_out_valid;
    logic [W-1:0]              r_drive;
    logic [INTEG_W-1:0]        r_integ_out;
    logic                      r_clamp;

    // combinational
    logic                      w_in_take;
    logic                      w_out_free;
    logic                      w_closed;
    logic signed [W-1:0]       w_setpoint;
    logic signed [W-1:0]       w_measured;
    logic signed [EW-1:0]      w_err;
    t_mul_req                  w_mul_req;
    logic signed [BW-1:0]      w_mul_b;
    logic signed [RW-1:0]      w_rnd;
    logic signed [XW-1:0]      w_int_sum;
    logic signed [INTEG_W-1:0] w_int_sat;
    logic                      w_hi;
    logic                      w_lo;
    logic signed [BCW-1:0]     w_bc;
    logic signed [INTEG_W-1:0] w_bc_sat;
    logic [W-1:0]              w_drive;
    logic signed [INTEG_W-1:0] w_integ_new;
    logic                      w_clamp;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_take     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TW'({r_integ_out, r_drive});
    assign m_axis_tuser  = r_clamp;

    // ------------------------------------------------------------------
    // register writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_integ_gain <= INTEG_GAIN_RST;
            r_step_time  <= STEP_TIME_RST;
            r_act_mode   <= MODE_OVERRIDE;
            r_bias       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PROP_GAIN:   r_prop_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:  r_integ_gain <= i_cfg_data[GAIN_W-1:0];
                REG_STEP_TIME:   r_step_time  <= i_cfg_data[GAIN_W-1:0];
                REG_ACT_MODE:    r_act_mode   <= i_cfg_data[MODE_W-1:0];
                REG_BIAS_OFFSET: r_bias       <= $signed(i_cfg_data[W-1:0]);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // error at accept time, negated for reverse acting
    // ------------------------------------------------------------------
    assign w_setpoint = $signed(s_axis_tdata[W-1:0]);
    assign w_measured = $signed(s_axis_tdata[2*W-1:W]);
    assign w_err      = EW'(w_setpoint) - EW'(w_measured);
    assign w_closed   = (r_act_mode == MODE_FORWARD) || (r_act_mode == MODE_REVERSE);

    // ------------------------------------------------------------------
    // shared multiplier: operand selection per step
    // ------------------------------------------------------------------
    always_comb begin
        w_mul_req.en   = 1'b0;
        w_mul_req.gain = r_prop_gain;
        w_mul_b        = BW'(r_err);
        unique case (r_state)
            S_MP: begin
                w_mul_req.en   = 1'b1;
                w_mul_req.gain = r_prop_gain;
            end
            S_MI: begin
                w_mul_req.en   = 1'b1;
                w_mul_req.gain = r_integ_gain;
            end
            S_MT: begin
                w_mul_req.en   = 1'b1;
                w_mul_req.gain = r_step_time;
                // rounded integral gain product always fits the operand width
                w_mul_b        = r_inc[BW-1:0];
            end
            default: ;
        endcase
    end

    pica_mul #(
        .BW     (BW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .i_opb  (w_mul_b),
        .o_rnd  (w_rnd)
    );

    // ------------------------------------------------------------------
    // integral update and limiter
    // ------------------------------------------------------------------
    assign w_int_sum = XW'(r_acc) + XW'(r_inc);

    always_comb begin
        if (w_int_sum > X_MAX) begin
            w_int_sat = INTEG_W'(X_MAX);
        end else if (w_int_sum < X_MIN) begin
            w_int_sat = INTEG_W'(X_MIN);
        end else begin
            w_int_sat = INTEG_W'(w_int_sum);
        end
    end

    assign w_hi = (r_sum > LIM_POS);
    assign w_lo = (r_sum < LIM_NEG);

    // excess beyond the positive or negative limit comes back off the integral
    assign w_bc = BCW'(r_integ) - (BCW'(r_sum) - (w_hi ? BCW'(LIM_POS) : BCW'(LIM_NEG)));

    always_comb begin
        if (w_bc > B_MAX) begin
            w_bc_sat = INTEG_W'(B_MAX);
        end else if (w_bc < B_MIN) begin
            w_bc_sat = INTEG_W'(B_MIN);
        end else begin
            w_bc_sat = INTEG_W'(w_bc);
        end
    end

    always_comb begin
        if (r_ovr) begin
            // open loop: bias straight through, integral cleared
            w_drive     = r_bias;
            w_integ_new = '0;
            w_clamp     = 1'b0;
        end else if (w_hi) begin
            w_drive     = DRV_POS;
            w_integ_new = w_bc_sat;
            w_clamp     = 1'b1;
        end else if (w_lo) begin
            w_drive     = DRV_NEG;
            w_integ_new = w_bc_sat;
            w_clamp     = 1'b1;
        end else begin
            w_drive     = r_sum[W-1:0];
            w_integ_new = r_integ;
            w_clamp     = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_state = w_closed ? S_MP : S_LIM;
                end
            end
            S_MP:  n_state = S_MI;
            S_MI:  n_state = S_MT0;
            S_MT0: n_state = S_MT;
            S_MT:  n_state = S_INC;
            S_INC: n_state = S_INT;
            S_INT: n_state = S_SUM;
            S_SUM: n_state = S_LIM;
            S_LIM: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LIM && w_out_free) begin
                r_out_valid <= 1'b1;
                r_acc       <= w_integ_new;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    r_err <= (r_act_mode == MODE_REVERSE) ? -w_err : w_err;
                    r_ovr <= !w_closed;
                end
            end
            S_MI:  r_prop  <= w_rnd;
            S_MT0: r_inc   <= w_rnd;
            S_INC: r_inc   <= w_rnd;
            S_INT: r_integ <= w_int_sat;
            S_SUM: r_sum   <= SW'(r_prop) + SW'(r_integ) + SW'(r_bias);
            S_LIM: begin
                if (w_out_free) begin
                    r_drive     <= w_drive;
                    r_integ_out <= w_integ_new;
                    r_clamp     <= w_clamp;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `PICA_ASSERT_SAME(a_clamp_at_limit, i_clk, i_rst_n, r_out_valid && r_clamp,
                      r_drive == DRV_POS || r_drive == DRV_NEG)
    `PICA_ASSERT_NEXT(a_take_leaves_idle, i_clk, i_rst_n, w_in_take, r_state != S_IDLE)
    `PICA_ASSERT_NEXT(a_override_clears, i_clk, i_rst_n,
                      r_state == S_LIM && r_ovr && w_out_free,
                      r_acc == '0 && !r_clamp && r_out_valid)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pi controller testbench
// drives setpoint/measured transactions through the pi controller under a
// sequence of register settings, predicts drive, integral and clamp flag
// for every accepted transaction and compares them with the result stream
// ----------------------------------------------------------------------------
module tb_top;

    import pica_pkg::*;

    localparam int SIG_W  = SIGNAL_WIDTH_DEF;
    localparam int IN_TW  = ((2 * SIG_W + 7) / 8) * 8;
    localparam int OUT_TW = ((SIG_W + INTEG_W + 7) / 8) * 8;
    localparam int CFG_W  = (SIG_W > GAIN_W) ? SIG_W : GAIN_W;

    // settle well past the closed-loop result of the last accept before a
    // register write
    localparam int RESULT_LATENCY = 8;
    localparam int SETTLE_CYCLES  = 2 * RESULT_LATENCY + 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int QUIET_TAIL     = 200;
    localparam int MAX_REPORTS    = 10;

    // code three is not in the package, the block treats it as override
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic signed [SIG_W-1:0] SIG_MAX = 16'sh7FFF;
    localparam logic signed [SIG_W-1:0] SIG_MIN = 16'sh8000;

    typedef struct {
        logic signed [SIG_W-1:0]   drive;
        logic signed [INTEG_W-1:0] integ;
        logic                      clamped;
    } t_pi_result;

    // clock, reset and block ports, all inputs known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_TW-1:0]     s_axis_tdata  = '0;  // setpoint, measured
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_TW-1:0]    m_axis_tdata;        // drive, integral_out
    logic [0:0]           m_axis_tuser;        // clamped
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    // predictor copy of the registers and the integral
    logic [GAIN_W-1:0]       kp_reg   = PROP_GAIN_RST;
    logic [GAIN_W-1:0]       ki_reg   = INTEG_GAIN_RST;
    logic [GAIN_W-1:0]       dt_reg   = STEP_TIME_RST;
    logic [MODE_W-1:0]       mode_reg = MODE_OVERRIDE;
    logic signed [SIG_W-1:0] bias_reg = '0;
    longint                  integ_acc = 0;

    t_pi_result pending_outputs[$];
    int         error_count  = 0;
    bit         idle_enabled = 1'b0;
    int         sink_hold    = 0;

    always #1 i_clk = ~i_clk;

    pi_controller_antiwindup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // divide by 2^8, nearest, ties toward plus infinity
    function automatic longint round_q8(input longint x);
        return (x + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    endfunction

    // clip to the q12.12 integral range
    function automatic longint sat_integ(input longint x);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (INTEG_W - 1)) - 1;
        lo = -(longint'(1) <<< (INTEG_W - 1));
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // one controller step on the accepted transaction; advances the integral
    task automatic compute_pi_step(input logic signed [SIG_W-1:0] sp,
                                   input logic signed [SIG_W-1:0] ms);
        t_pi_result r;
        longint     err;
        longint     prop;
        longint     step_inc;
        longint     acc;
        longint     total;
        r.clamped = 1'b0;
        if (mode_reg == MODE_FORWARD || mode_reg == MODE_REVERSE) begin
            err = longint'(sp) - longint'(ms);
            if (mode_reg == MODE_REVERSE) begin
                err = -err;
            end
            prop     = round_q8(longint'(kp_reg) * err);
            step_inc = round_q8(longint'(ki_reg) * err);
            step_inc = round_q8(step_inc * longint'(dt_reg));
            acc      = sat_integ(integ_acc + step_inc);
            total    = prop + acc + longint'(bias_reg);
            // back-calculation: the excess beyond the limit leaves the integral
            if (total > ONE_FIXED) begin
                acc       = sat_integ(acc - (total - ONE_FIXED));
                total     = ONE_FIXED;
                r.clamped = 1'b1;
            end else if (total < -ONE_FIXED) begin
                acc       = sat_integ(acc - (total + ONE_FIXED));
                total     = -ONE_FIXED;
                r.clamped = 1'b1;
            end
        end else begin
            // override and the spare code: open loop, integral cleared
            total = longint'(bias_reg);
            acc   = 0;
        end
        integ_acc = acc;
        r.drive   = total[SIG_W-1:0];
        r.integ   = acc[INTEG_W-1:0];
        pending_outputs.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // register write, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            REG_PROP_GAIN:   kp_reg   = value[GAIN_W-1:0];
            REG_INTEG_GAIN:  ki_reg   = value[GAIN_W-1:0];
            REG_STEP_TIME:   dt_reg   = value[GAIN_W-1:0];
            REG_ACT_MODE:    mode_reg = value[MODE_W-1:0];
            REG_BIAS_OFFSET: bias_reg = value[SIG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one input transaction, optional gap first; returns on acceptance
    task automatic send_sample(input logic signed [SIG_W-1:0] sp,
                               input logic signed [SIG_W-1:0] ms);
        int gap;
        @(negedge i_clk);
        if (idle_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ms, sp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        compute_pi_step(sp, ms);
    endtask

    // stop sending, let every expected result arrive and the sequencer settle
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side back-pressure in random bursts
    always @(negedge i_clk) begin
        if (sink_hold == 0 && idle_enabled && $urandom_range(0, 3) == 0) begin
            sink_hold = $urandom_range(1, 6);
        end
        if (sink_hold != 0) begin
            sink_hold = sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_pi_result                want;
        logic signed [SIG_W-1:0]   got_drive;
        logic signed [INTEG_W-1:0] got_integ;
        logic                      got_clamped;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_drive   = m_axis_tdata[SIG_W-1:0];
            got_integ   = m_axis_tdata[SIG_W+INTEG_W-1:SIG_W];
            got_clamped = m_axis_tuser[0];
            if (pending_outputs.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("unexpected result: drive %0d integral %0d clamped %0b",
                             got_drive, got_integ, got_clamped);
                end
            end else begin
                want = pending_outputs.pop_front();
                if (got_drive !== want.drive || got_integ !== want.integ
                        || got_clamped !== want.clamped) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("mismatch: expected drive %0d integral %0d clamped %0b",
                                 want.drive, want.integ, want.clamped);
                        $display("          actual   drive %0d integral %0d clamped %0b",
                                 got_drive, got_integ, got_clamped);
                    end
                end
            end
        end
    end

    // watchdog: too long without any transaction on either side
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // random picks
    // ------------------------------------------------------------------
    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom_range(0, 1023));
            3:       return GAIN_W'($urandom_range(0, 65535));
            default: return GAIN_W'($urandom_range(0, 400));
        endcase
    endfunction

    function automatic logic signed [SIG_W-1:0] pick_bias();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return SIG_MAX;
            2:       return SIG_MIN;
            3:       return SIG_W'($urandom_range(0, 65535));
            default: return SIG_W'(int'($urandom_range(0, 4096)) - 2048);
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        case ($urandom_range(0, 9))
            0:       return MODE_OVERRIDE;
            1:       return MODE_SPARE;
            2, 3, 4, 5: return MODE_FORWARD;
            default: return MODE_REVERSE;
        endcase
    endfunction

    function automatic logic signed [SIG_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return SIG_MAX;
            1:       return SIG_MIN;
            2:       return '0;
            3:       return 16'sd1;
            default: return -16'sd1;
        endcase
    endfunction

    // errors mostly small so the loop spends time inside the limits
    task automatic send_random_sample();
        logic signed [SIG_W-1:0] sp;
        logic signed [SIG_W-1:0] ms;
        int                      delta;
        case ($urandom_range(0, 3))
            0: begin
                sp = SIG_W'($urandom_range(0, 65535));
                ms = SIG_W'($urandom_range(0, 65535));
            end
            1: begin
                sp    = SIG_W'($urandom_range(0, 65535));
                delta = int'($urandom_range(0, 600)) - 300;
                ms    = SIG_W'(int'(sp) + delta);
            end
            2: begin
                sp = SIG_W'(int'($urandom_range(0, 4096)) - 2048);
                ms = SIG_W'(int'($urandom_range(0, 4096)) - 2048);
            end
            default: begin
                sp = pick_extreme();
                ms = pick_extreme();
            end
        endcase
        send_sample(sp, ms);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // register defaults: open loop with zero bias, then unity gain, no integral gain
    task automatic test_reset_defaults();
        send_sample(SIG_MAX, SIG_MIN);
        send_sample(SIG_MIN, SIG_MAX);
        wait_idle();
        write_reg(REG_ACT_MODE, CFG_W'(MODE_FORWARD));
        send_sample('0, '0);
        send_sample(16'sd100, -16'sd50);
        send_sample(SIG_MAX, SIG_MIN);
        send_sample(SIG_MIN, SIG_MAX);
    endtask

    // reverse acting, override with extreme biases, the spare mode code
    task automatic test_mode_codes();
        wait_idle();
        write_reg(REG_ACT_MODE, CFG_W'(MODE_REVERSE));
        send_sample(16'sd300, 16'sd1000);
        send_sample(SIG_MAX, '0);
        wait_idle();
        write_reg(REG_BIAS_OFFSET, CFG_W'(SIG_MAX));
        write_reg(REG_ACT_MODE, CFG_W'(MODE_OVERRIDE));
        send_sample(SIG_MIN, SIG_MAX);
        send_sample(16'sd7, -16'sd7);
        wait_idle();
        write_reg(REG_BIAS_OFFSET, CFG_W'(SIG_MIN));
        write_reg(REG_ACT_MODE, CFG_W'(MODE_SPARE));
        send_sample(SIG_MAX, SIG_MIN);
        send_sample('0, '0);
    endtask

    // integral saturation at both ends, before and after back-calculation
    task automatic test_integral_limits();
        wait_idle();
        write_reg(REG_BIAS_OFFSET, '0);
        write_reg(REG_PROP_GAIN, '0);
        write_reg(REG_INTEG_GAIN, '1);
        write_reg(REG_STEP_TIME, '1);
        write_reg(REG_ACT_MODE, CFG_W'(MODE_FORWARD));
        send_sample(SIG_MAX, SIG_MIN);
        wait_idle();
        write_reg(REG_PROP_GAIN, '1);
        write_reg(REG_INTEG_GAIN, '0);
        send_sample(SIG_MIN, SIG_MAX);
        send_sample(SIG_MAX, SIG_MIN);
        wait_idle();
        // zero step time: no integral growth whatever the gain
        write_reg(REG_PROP_GAIN, '0);
        write_reg(REG_INTEG_GAIN, '1);
        write_reg(REG_STEP_TIME, '0);
        send_sample(16'sd1234, -16'sd999);
    endtask

    // half-lsb products round upward for both signs
    task automatic test_rounding_ties();
        wait_idle();
        write_reg(REG_PROP_GAIN, CFG_W'(128));
        write_reg(REG_INTEG_GAIN, '0);
        write_reg(REG_STEP_TIME, CFG_W'(256));
        write_reg(REG_BIAS_OFFSET, '0);
        send_sample(16'sd1, '0);
        send_sample('0, 16'sd1);
    endtask

    // random register settings per phase, random transactions within
    task automatic test_random_traffic();
        int sent;
        int phase;
        int phase_len;
        int k;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            idle_enabled = (sent < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            write_reg(REG_PROP_GAIN, pick_gain());
            write_reg(REG_INTEG_GAIN, pick_gain());
            write_reg(REG_STEP_TIME, pick_gain());
            write_reg(REG_BIAS_OFFSET, CFG_W'(pick_bias()));
            write_reg(REG_ACT_MODE, CFG_W'(pick_mode()));
            phase_len = $urandom_range(20, 90);
            for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                // sender holds off until the pipeline has emptied
                if (k == phase_len / 2 && (phase == 0 || $urandom_range(0, 2) == 0)) begin
                    wait_idle();
                end
                send_random_sample();
                sent++;
            end
            phase++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_enabled = 1'b1;
        test_reset_defaults();
        test_mode_codes();
        test_integral_limits();
        test_rounding_ties();
        test_random_traffic();
        idle_enabled = 1'b0;
        wait_idle();
        if (error_count == 0 && pending_outputs.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/pica_pkg.sv
hdl/pica_mul.sv
hdl/pi_controller_antiwindup.sv
tb/tb_top.sv
